### hw/rtl/pfct_pkg.sv
package pfct_pkg;

    localparam int KEY_W   = 48;
    localparam int CHUNK_W = 32;
    localparam int SLOT_W  = 3;

    localparam logic [1:0] VERDICT_FULL   = 2'd0;
    localparam logic [1:0] VERDICT_AHEAD  = 2'd1;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd2;
    localparam logic [1:0] VERDICT_STALE  = 2'd3;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [CHUNK_W-1:0] count_t;

    typedef struct packed {
        logic [1:0]               verdict;
        logic                     send_ack;
        logic                     deliver;
        logic                     flow_closed;
        logic [SLOT_W-1:0]        slot_index;
        logic signed [CHUNK_W-1:0] ack_chunk;
    } result_t;

    // Outcome of the scan, handed to the judging unit.
    typedef struct packed {
        logic   hit;
        logic   free_found;
        count_t hit_count;
    } scan_sum_t;

endpackage

### hw/rtl/pfct_hdr_if.sv
interface pfct_hdr_if;
    logic                valid;
    logic                ready;
    logic [31:0]         src_ip;
    logic [15:0]         src_port;
    logic signed [31:0]  chunk_number;
    logic                last_chunk;

    modport source (output valid, output src_ip, output src_port, output chunk_number,
                    output last_chunk, input ready);
    modport sink (input valid, input src_ip, input src_port, input chunk_number,
                  input last_chunk, output ready);
endinterface

### hw/rtl/pfct_res_if.sv
interface pfct_res_if;
    logic                valid;
    logic                ready;
    logic [1:0]          verdict;
    logic                send_ack;
    logic                deliver;
    logic                flow_closed;
    logic [2:0]          slot_index;
    logic signed [31:0]  ack_chunk;

    modport source (output valid, output verdict, output send_ack, output deliver,
                    output flow_closed, output slot_index, output ack_chunk, input ready);
    modport sink (input valid, input verdict, input send_ack, input deliver,
                  input flow_closed, input slot_index, input ack_chunk, output ready);
endinterface

### hw/rtl/pfct_ram.sv
module pfct_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/pfct_judge.sv
module pfct_judge #(
    parameter int FLOW_SLOTS = 8,
    localparam int AW        = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1
) (
    input  pfct_pkg::scan_sum_t  scan,
    input  logic [AW-1:0]        hit_slot,
    input  logic [AW-1:0]        free_slot,
    input  logic signed [31:0]   chunk,
    input  logic                 last,
    output pfct_pkg::result_t    result,
    output logic                 write_en,
    output logic [AW-1:0]        write_slot,
    output pfct_pkg::count_t     write_count,
    output logic                 in_use_val
);

    logic                full;
    pfct_pkg::count_t    count;
    logic signed [32:0]  expected;
    logic signed [32:0]  chunk_ext;
    logic                ahead;
    logic                accept;

    always_comb
    begin
        full       = !scan.hit && !scan.free_found;
        write_slot = scan.hit ? hit_slot : free_slot;
        count      = scan.hit ? scan.hit_count : '0;
        // One bit wider than the count, so the top count never wraps.
        expected   = $signed({count[31], count}) + 33'sd1;
        chunk_ext  = $signed({chunk[31], chunk});
        ahead      = chunk_ext > expected;
        accept     = chunk_ext == expected;

        result = '0;
        if (!full)
        begin
            result.slot_index = 3'(write_slot);
            if (ahead)
            begin
                result.verdict = pfct_pkg::VERDICT_AHEAD;
            end
            else
            begin
                result.verdict     = accept ? pfct_pkg::VERDICT_ACCEPT
                                            : pfct_pkg::VERDICT_STALE;
                result.send_ack    = 1'b1;
                result.deliver     = accept;
                result.flow_closed = accept && last;
                result.ack_chunk   = chunk;
            end
        end

        // A claimed slot is written even when its first chunk is ahead.
        write_en    = !full && (!scan.hit || accept);
        write_count = accept ? pfct_pkg::count_t'(chunk) : '0;
        in_use_val  = !(accept && last);
    end

endmodule

### hw/rtl/per_flow_in_order_chunk_tracker_core.sv
// Per-flow in-order chunk tracker.
// The hdr channel carries one datagram header per transfer (source address,
// source port, chunk number, last flag); the res channel returns exactly one
// verdict per header, in order.
// After a header is taken the block scans its flow table, one slot per cycle
// through the single read port of the table memory, then judges the chunk
// against the expected number and updates the slot in its judging step.
// A new header is taken only once the last one has been judged; hdr.ready is
// low while a header is in work.
// A finished result sits in an output register, so the next header may be
// taken while it waits. If the receiver stalls so long that a second result
// is ready before the first has gone, the block holds in its judging step
// and the table is not touched until the output register is free.
// Reset marks every slot free and empties the output register; the address
// and count memory needs no clearing, as the data of free slots is never used.
module per_flow_in_order_chunk_tracker_core #(
    parameter int FLOW_SLOTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    pfct_hdr_if.sink      hdr,
    pfct_res_if.source    res
);

    localparam int AW    = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int CW    = $clog2(FLOW_SLOTS + 1);
    localparam int ENT_W = pfct_pkg::KEY_W + pfct_pkg::CHUNK_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_JUDGE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [FLOW_SLOTS-1:0]  in_use_reg, in_use_next;
    pfct_pkg::scan_sum_t    scan_reg, scan_next;
    logic [AW-1:0]          hit_slot_reg, hit_slot_next;
    logic [AW-1:0]          free_slot_reg, free_slot_next;
    logic                   out_vld_reg, out_vld_next;
    pfct_pkg::result_t      out_reg, out_next;
    pfct_pkg::key_t         key_reg, key_next;
    logic signed [31:0]     chunk_reg, chunk_next;
    logic                   last_reg, last_next;

    logic                   ram_we;
    logic [ENT_W-1:0]       ram_wdata;
    logic [ENT_W-1:0]       ram_rdata;
    pfct_pkg::key_t         rd_key;
    logic                   key_match;
    logic                   judge_fire;

    pfct_pkg::result_t      j_result;
    logic                   j_write_en;
    logic [AW-1:0]          j_write_slot;
    pfct_pkg::count_t       j_write_count;
    logic                   j_in_use_val;

    pfct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FLOW_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (j_write_slot),
        .wdata (ram_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    pfct_judge #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_judge (
        .scan        (scan_reg),
        .hit_slot    (hit_slot_reg),
        .free_slot   (free_slot_reg),
        .chunk       (chunk_reg),
        .last        (last_reg),
        .result      (j_result),
        .write_en    (j_write_en),
        .write_slot  (j_write_slot),
        .write_count (j_write_count),
        .in_use_val  (j_in_use_val)
    );

    assign rd_key     = ram_rdata[ENT_W-1 -: pfct_pkg::KEY_W];
    assign key_match  = rd_key == key_reg;
    assign judge_fire = (state_reg == S_JUDGE) && (!out_vld_reg || res.ready);
    assign ram_we     = judge_fire && j_write_en;
    assign ram_wdata  = {key_reg, j_write_count};

    assign hdr.ready       = state_reg == S_IDLE;
    assign res.valid       = out_vld_reg;
    assign res.verdict     = out_reg.verdict;
    assign res.send_ack    = out_reg.send_ack;
    assign res.deliver     = out_reg.deliver;
    assign res.flow_closed = out_reg.flow_closed;
    assign res.slot_index  = out_reg.slot_index;
    assign res.ack_chunk   = out_reg.ack_chunk;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        in_use_next    = in_use_reg;
        scan_next      = scan_reg;
        hit_slot_next  = hit_slot_reg;
        free_slot_next = free_slot_reg;
        out_vld_next   = out_vld_reg;
        out_next       = out_reg;
        key_next       = key_reg;
        chunk_next     = chunk_reg;
        last_next      = last_reg;

        if (res.ready)
        begin
            out_vld_next = 1'b0;
        end

        // Compare stage: the memory data for the slot read last cycle.
        if (cmp_vld_reg)
        begin
            if (!in_use_reg[cmp_idx_reg])
            begin
                // Later slots overwrite, leaving the highest free one.
                scan_next.free_found = 1'b1;
                free_slot_next       = cmp_idx_reg;
            end
            else if (key_match)
            begin
                scan_next.hit       = 1'b1;
                scan_next.hit_count = ram_rdata[pfct_pkg::CHUNK_W-1:0];
                hit_slot_next       = cmp_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (hdr.valid)
                begin
                    key_next   = {hdr.src_ip, hdr.src_port};
                    chunk_next = hdr.chunk_number;
                    last_next  = hdr.last_chunk;
                    cnt_next   = '0;
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != CW'(FLOW_SLOTS))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                if (judge_fire)
                begin
                    out_vld_next = 1'b1;
                    out_next     = j_result;
                    if (j_write_en)
                    begin
                        in_use_next[j_write_slot] = j_in_use_val;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            in_use_reg  <= '0;
            scan_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            in_use_reg  <= in_use_next;
            scan_reg    <= scan_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        hit_slot_reg  <= hit_slot_next;
        free_slot_reg <= free_slot_next;
        out_reg       <= out_next;
        key_reg       <= key_next;
        chunk_reg     <= chunk_next;
        last_reg      <= last_next;
    end

endmodule

### hw/rtl/pfct_checker.sv
module pfct_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               hdr_valid,
    input logic               hdr_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         verdict,
    input logic               send_ack,
    input logic               deliver,
    input logic               flow_closed,
    input logic [2:0]         slot_index,
    input logic signed [31:0] ack_chunk
);

    // A stalled result keeps its contents until the transfer completes.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(verdict) && $stable(send_ack)
            && $stable(deliver) && $stable(flow_closed) && $stable(slot_index)
            && $stable(ack_chunk))
        else $error("result changed while stalled");

    // hdr.ready stays low through the table scan, so a header is never followed at once.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_ready |=> !hdr_ready)
        else $error("header taken on consecutive cycles");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && verdict == pfct_pkg::VERDICT_FULL |-> !send_ack && !deliver
            && !flow_closed && slot_index == 3'd0 && ack_chunk == 32'sd0)
        else $error("dropped header carries a reply");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (deliver == (verdict == pfct_pkg::VERDICT_ACCEPT))
            && (send_ack == (verdict == pfct_pkg::VERDICT_ACCEPT
                             || verdict == pfct_pkg::VERDICT_STALE))
            && (!flow_closed || deliver))
        else $error("result flags disagree with verdict");

endmodule

bind per_flow_in_order_chunk_tracker_core pfct_checker u_pfct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .hdr_valid   (hdr.valid),
    .hdr_ready   (hdr.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .verdict     (res.verdict),
    .send_ack    (res.send_ack),
    .deliver     (res.deliver),
    .flow_closed (res.flow_closed),
    .slot_index  (res.slot_index),
    .ack_chunk   (res.ack_chunk)
);
